[hw/rtl/rau_pkg.sv]
package rau_pkg;

	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_ZERO = 2'd1,
		ERR_OVF  = 2'd2
	} err_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         error;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMB,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic comb;
		logic gcd_step;
		logic div_start;
		logic div_sel_den;
		logic div_step;
		logic fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} sts_t;

endpackage

[hw/rtl/rau_ctrl.sv]
module rau_ctrl import rau_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  sts_t   sts,
	output logic   busy,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d = ST_COMB;
			end
			ST_COMB: begin
				cmd.comb = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (sts.early) begin
					state_d = ST_DONE;
				end else if (sts.gcd_done) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIVN: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel_den = 1'b1;
					state_d = ST_DIVD;
				end
			end
			ST_DIVD: begin
				cmd.div_step = 1'b1;
				cmd.div_sel_den = 1'b1;
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy) else $error("load while busy");
	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> !cmd.fin) else $error("double finish");
	a_load_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_MUL1) else $error("load did not advance");

endmodule

[hw/rtl/rau_dp.sv]
module rau_dp import rau_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output logic done,
	output rsp_t rsp
);

	localparam int W = VALUE_BITS;
	localparam int W2 = 2 * VALUE_BITS;
	localparam int CW = $clog2(W2 + 1);

	logic [1:0]    kind_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          sa_q, sb_q, bad_q;
	logic [W2-1:0] pa_q, pb_q, den_q, num_q;
	logic          neg_q;
	logic [W2-1:0] gx_q, gy_q;
	// restoring divider
	logic [W2-1:0] dq_q, dr_q;
	logic [CW-1:0] dcnt_q;
	logic [W2-1:0] qn_q, qd_q;
	logic          early_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          done_q;

	function automatic logic [W:0] mag(input logic [31:0] raw);
		logic [W-1:0] v;
		v = raw[W-1:0];
		mag = v[W-1] ? ({1'b0, {W{1'b0}}} - {1'b0, v}) : {1'b0, v};
	endfunction

	logic [W:0] an_m, ad_m, bn_m, bd_m;
	assign an_m = mag(req.a_num);
	assign ad_m = mag(req.a_den);
	assign bn_m = mag(req.b_num);
	assign bd_m = mag(req.b_den);

	// magnitudes hold 2^(W-1) at most, so W bits suffice
	logic [W-1:0] m1a, m1b;
	always_comb begin
		m1a = an_q; m1b = bd_q;
		unique case (1'b1)
			cmd.mul2: begin
				if (kind_q == KIND_DIV) begin m1a = ad_q; m1b = bn_q; end
				else if (kind_q == KIND_MUL) begin m1a = an_q; m1b = bn_q; end
				else begin m1a = bn_q; m1b = ad_q; end
			end
			cmd.mul3: begin
				m1a = ad_q; m1b = bd_q;
			end
			default: begin m1a = an_q; m1b = bd_q; end
		endcase
	end
	logic [W2-1:0] prod;
	assign prod = m1a * m1b;

	logic [W2-1:0] gmod;
	logic [W2-1:0] dtrial;
	logic [W2-1:0] dshift;
	logic [W2-1:0] dquot;
	assign dshift = {dr_q[W2-2:0], dq_q[W2-1]};
	assign dtrial = dshift - gx_q;
	assign dquot = {dq_q[W2-2:0], (dshift >= gx_q)};

	logic [W2-1:0] half;
	assign half = {{(W2-1){1'b0}}, 1'b1} << (W - 1);

	// final result: error, zero, range check, or the reduced fraction
	always_comb begin
		rsp_d = '0;
		if (bad_q) begin
			rsp_d.error = ERR_ZERO;
		end else if (early_q) begin
			rsp_d.res_den = 31'd1;
		end else if ((neg_q ? (qn_q > half) : (qn_q > half - 1'b1)) ||
			(qd_q > half - 1'b1)) begin
			rsp_d.error = ERR_OVF;
		end else begin
			rsp_d.res_num = 32'(signed'(neg_q ? ({W2{1'b0}} - qn_q) : qn_q));
			rsp_d.res_den = 31'(qd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			an_q <= an_m[W-1:0];
			ad_q <= ad_m[W-1:0];
			bn_q <= bn_m[W-1:0];
			bd_q <= bd_m[W-1:0];
			sa_q <= req.a_num[W-1] ^ req.a_den[W-1];
			sb_q <= (req.b_num[W-1] ^ req.b_den[W-1]) ^ (req.kind == KIND_SUB);
			bad_q <= (ad_m == '0) || (bd_m == '0) ||
				((req.kind == KIND_DIV) && (bn_m == '0));
		end
		if (cmd.mul1) pa_q <= prod;
		if (cmd.mul2) pb_q <= prod;
		if (cmd.mul3) den_q <= prod;
		if (cmd.comb) begin
			// add/sub combine; multiply and divide take pa/pb directly
			if (kind_q == KIND_MUL) begin
				num_q <= pb_q; neg_q <= sa_q ^ sb_q;
				den_q <= den_q;
			end else if (kind_q == KIND_DIV) begin
				num_q <= pa_q; neg_q <= sa_q ^ sb_q;
				den_q <= pb_q;
			end else if (sa_q == sb_q) begin
				num_q <= pa_q + pb_q; neg_q <= sa_q;
			end else if (pa_q >= pb_q) begin
				num_q <= pa_q - pb_q; neg_q <= sa_q;
			end else begin
				num_q <= pb_q - pa_q; neg_q <= sb_q;
			end
			early_q <= 1'b0;
		end
		if (cmd.comb) begin
			gx_q <= '0; gy_q <= '0;
		end
		// Euclid on the shared divider, one remainder per pass
		if (cmd.gcd_step) begin
			if (gx_q == '0 && gy_q == '0) begin
				gx_q <= num_q; gy_q <= den_q;
				dcnt_q <= '0;
			end else if (dcnt_q == '0) begin
				dq_q <= gx_q; dr_q <= '0;
				dcnt_q <= CW'(W2);
				gx_q <= gy_q; gy_q <= gx_q;
			end else begin
				dr_q <= (dtrial[W2-1] == 1'b0 && dshift >= gx_q) ? dtrial : dshift;
				dq_q <= {dq_q[W2-2:0], 1'b0};
				dcnt_q <= dcnt_q - 1'b1;
				if (dcnt_q == CW'(1)) begin
					gy_q <= (dshift >= gx_q) ? dtrial : dshift;
				end
			end
		end
		if (cmd.div_start) begin
			dq_q <= cmd.div_sel_den ? den_q : num_q;
			dr_q <= '0;
			dcnt_q <= CW'(W2);
		end else if (cmd.div_step) begin
			dr_q <= (dshift >= gx_q) ? dtrial : dshift;
			dq_q <= dquot;
			dcnt_q <= dcnt_q - 1'b1;
		end
		// the numerator pass ends in the cycle that starts the denominator pass
		if (cmd.div_step && dcnt_q == CW'(1)) begin
			if (cmd.div_sel_den && !cmd.div_start) qd_q <= dquot;
			else                                   qn_q <= dquot;
		end
		if (cmd.fin) rsp_q <= rsp_d;
		if (sts.early && !cmd.comb) early_q <= 1'b1;
	end

	assign gmod = gy_q;
	// done with gcd when the second Euclid operand reaches zero between passes
	assign sts.gcd_done = (dcnt_q == '0) && (gmod == '0) && (gx_q != '0);
	assign sts.div_done = (dcnt_q == CW'(1));
	assign sts.early = bad_q || (num_q == '0 && gx_q == '0 && gy_q == '0 && !cmd.comb);
	assign done = done_q;
	assign rsp = rsp_q;

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !cmd.div_start && dcnt_q != '0) |=> dcnt_q == $past(dcnt_q) - 1'b1)
		else $error("divider count skipped");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.error != ERR_NONE) |-> (rsp.res_den == '0 && rsp.res_num == '0))
		else $error("error result with payload");

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: one reduced fraction per command.
// One shared bit-serial divider is used for gcd and the final exact divides.
// Throughput: one command at a time; busy stays high until done pulses.
// Reset: arst_n clears the controller to idle and drops done; payload is not reset.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequence the multiply, combine, gcd and divide steps
	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// hold operands, products and the shared divider
	rau_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Bench for the rational arithmetic unit. The sender presents one beat and
// holds it until busy lets it in. Every result is checked against an
// in-bench fraction reducer, or against a value typed into the directed table.
module tb_top;
	import rau_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int TAIL_CYCLES    = 8000;

	typedef struct {
		req_t r;
		bit   fixed;
		rsp_t x;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	rsp_t pending_results[$];
	row_t directed_rows[$];
	int   mismatches;
	int   stall_cycles;
	int   sender_idle_pct;

	rational_arithmetic_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Magnitude of a 32-bit two's complement value, exact for the minimum.
	function automatic longint unsigned mag32(logic [31:0] v);
		if (v[31])
			return 64'h1_0000_0000 - {32'd0, v};
		return {32'd0, v};
	endfunction

	// Exact fraction result, reduced by Euclid, sign on the numerator.
	function automatic rsp_t reduce_fraction(req_t r);
		longint unsigned an, ad, bn, bd, pa, pb, num, den, g, x, y, t;
		longint unsigned half;
		bit sa, sb, neg;
		rsp_t o;
		o = '0;
		an = mag32(r.a_num);
		ad = mag32(r.a_den);
		bn = mag32(r.b_num);
		bd = mag32(r.b_den);
		sa = r.a_num[31] ^ r.a_den[31];
		sb = r.b_num[31] ^ r.b_den[31];
		if (ad == 0 || bd == 0 || (kind_t'(r.kind) == KIND_DIV && bn == 0)) begin
			o.error = ERR_ZERO;
			return o;
		end
		case (kind_t'(r.kind))
			KIND_ADD, KIND_SUB: begin
				pa = an * bd;
				pb = bn * ad;
				if (kind_t'(r.kind) == KIND_SUB)
					sb = ~sb;
				den = ad * bd;
				if (sa == sb) begin
					num = pa + pb;
					neg = sa;
				end else if (pa >= pb) begin
					num = pa - pb;
					neg = sa;
				end else begin
					num = pb - pa;
					neg = sb;
				end
			end
			KIND_MUL: begin
				num = an * bn;
				den = ad * bd;
				neg = sa ^ sb;
			end
			default: begin
				num = an * bd;
				den = ad * bn;
				neg = sa ^ sb;
			end
		endcase
		if (num == 0) begin
			o.res_den = 31'd1;
			return o;
		end
		x = num;
		y = den;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		g = x;
		num = num / g;
		den = den / g;
		half = 64'h8000_0000;
		if ((neg ? (num > half) : (num > half - 1)) || den > half - 1) begin
			o.error = ERR_OVF;
			return o;
		end
		o.res_num = neg ? (32'd0 - num[31:0]) : num[31:0];
		o.res_den = den[30:0];
		o.error = ERR_NONE;
		return o;
	endfunction

	function automatic req_t mk_req(kind_t k, int an, int ad, int bn, int bd);
		req_t r;
		r.kind = k;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(int n, int d, err_t e);
		rsp_t o;
		o.res_num = n;
		o.res_den = d[30:0];
		o.error = e;
		return o;
	endfunction

	// Operand value: mostly small with shared factors, some full-width, some corner values.
	function automatic logic [31:0] pick_value(int factor, bit is_den);
		int sel;
		sel = $urandom_range(0, 19);
		if (is_den && sel == 0)
			return 32'd0;
		if (sel < 11)
			return $signed($urandom_range(0, 40)) - 20 == 0 && is_den ?
				32'd7 : ($signed($urandom_range(0, 40)) - 20) * factor;
		if (sel < 16)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd1;
			4: return 32'h8000_0001;
			default: return is_den ? 32'd3 : 32'd0;
		endcase
	endfunction

	// Result beat: compare against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result num=%0d den=%0d err=%0d",
						rsp.res_num, rsp.res_den, rsp.error);
			end else begin
				rsp_t want;
				want = pending_results.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d err %0d, got %0d/%0d err %0d",
							want.res_num, want.res_den, want.error,
							rsp.res_num, rsp.res_den, rsp.error);
				end
			end
		end
	end

	// Watchdog: count cycles with no beat moving in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Present one beat at the falling edge, hold it until the unit takes it.
	task automatic send_beat(req_t r, bit fixed, rsp_t x);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < sender_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(fixed ? x : reduce_fraction(r));
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		req_t r;
		int factor;
		sender_idle_pct = 15;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;

		// Directed rows: typed expectations where obvious, the rest predicted.
		directed_rows.push_back('{mk_req(KIND_ADD, 1, 0, 1, 1), 1, mk_rsp(0, 0, ERR_ZERO)});
		directed_rows.push_back('{mk_req(KIND_MUL, 1, 1, 1, 0), 1, mk_rsp(0, 0, ERR_ZERO)});
		directed_rows.push_back('{mk_req(KIND_DIV, 1, 0, 0, 1), 1, mk_rsp(0, 0, ERR_ZERO)});
		directed_rows.push_back('{mk_req(KIND_DIV, 3, 4, 0, 5), 1, mk_rsp(0, 0, ERR_ZERO)});
		directed_rows.push_back('{mk_req(KIND_SUB, 2, 3, 2, 3), 1, mk_rsp(0, 1, ERR_NONE)});
		directed_rows.push_back('{mk_req(KIND_MUL, 0, -7, 5, 3), 1, mk_rsp(0, 1, ERR_NONE)});
		directed_rows.push_back('{mk_req(KIND_ADD, 0, 5, 0, -9), 1, mk_rsp(0, 1, ERR_NONE)});
		// most negative over minus one is the exact value 2^31: out of range
		directed_rows.push_back('{mk_req(KIND_MUL, 32'h8000_0000, -1, 1, 1), 1,
			mk_rsp(0, 0, ERR_OVF)});
		directed_rows.push_back('{mk_req(KIND_MUL, 32'h8000_0000, 1, 1, 1), 1,
			mk_rsp(32'h8000_0000, 1, ERR_NONE)});
		directed_rows.push_back('{mk_req(KIND_ADD, 32'h7fff_ffff, 1, 0, 1), 1,
			mk_rsp(32'h7fff_ffff, 1, ERR_NONE)});
		// denominator of 2^31 after sign move cannot be represented
		directed_rows.push_back('{mk_req(KIND_MUL, 1, 32'h8000_0000, 1, 1), 1,
			mk_rsp(0, 0, ERR_OVF)});
		directed_rows.push_back('{mk_req(KIND_ADD, 32'h7fff_ffff, 1, 1, 1), 1,
			mk_rsp(0, 0, ERR_OVF)});
		directed_rows.push_back('{mk_req(KIND_ADD, 1, 6, 1, 4), 0, '0});
		directed_rows.push_back('{mk_req(KIND_SUB, 1, 6, 3, 4), 0, '0});
		directed_rows.push_back('{mk_req(KIND_MUL, -4, 6, 9, -10), 0, '0});
		directed_rows.push_back('{mk_req(KIND_DIV, 5, -12, -25, 18), 0, '0});
		directed_rows.push_back('{mk_req(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000), 0, '0});
		directed_rows.push_back('{mk_req(KIND_DIV, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff), 0, '0});
		directed_rows.push_back('{mk_req(KIND_ADD, 32'h7fff_ffff, 32'h7fff_fffe,
			32'h7fff_fffd, 32'h7fff_ffff), 0, '0});
		directed_rows.push_back('{mk_req(KIND_MUL, -1, -1, -1, -1), 0, '0});
		directed_rows.push_back('{mk_req(KIND_DIV, 1, 1, -1, 32'h7fff_ffff), 0, '0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].r, directed_rows[i].fixed, directed_rows[i].x);

		// Random part in three idling phases; drain between phases.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				start <= 1'b0;
				drain_results();
				sender_idle_pct = 45;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				start <= 1'b0;
				drain_results();
				sender_idle_pct = 0;
			end
			factor = $urandom_range(1, 30);
			r.kind = 2'($urandom_range(0, 3));
			r.a_num = pick_value(factor, 0);
			r.a_den = pick_value(factor, 1);
			r.b_num = pick_value(factor, 0);
			r.b_den = pick_value(factor, 1);
			send_beat(r, 0, '0);
		end
		start <= 1'b0;

		// Hold until every result has come back, then let the tail run out.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

[rational_arithmetic_unit.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_arithmetic_unit.sv
bench/tb_top.sv
